// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/cicu_pkg.sv =====
// ----------------------------------------------------------------------------
// Contact impulse cone update package
// Default widths shared by the pipeline modules.
// ----------------------------------------------------------------------------
package cicu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MU_WIDTH   = 20;

endpackage

// ===== sv/cicu_front.sv =====
// ----------------------------------------------------------------------------
// Contact impulse cone update front end
// Six stages: input magnitudes, row products, rounding and saturation, normal
// clamp, tangent squares, then friction limit and squared tangent norm.
// ----------------------------------------------------------------------------
module cicu_front #(
    parameter int W = cicu_pkg::DATA_WIDTH,
    parameter int F = cicu_pkg::FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            valid_in,
    input  logic                            kind_in,
    input  logic [cicu_pkg::MU_WIDTH-1:0]   mu_in,
    input  logic [2:0][W-1:0]               p_in,
    input  logic [2:0][W-1:0]               y_in,
    input  logic [2:0][W-2:0]               r_in,
    output logic                            valid_out,
    output logic                            kind_out,
    output logic [W-2:0]                    pn_out,
    output logic [W:0]                      lim_out,
    output logic [W-1:0]                    t1_out,
    output logic [W-1:0]                    t2_out,
    output logic [W-1:0]                    mt1_out,
    output logic [W-1:0]                    mt2_out,
    output logic [2*W-1:0]                  sq_out
);

    localparam int MUW = cicu_pkg::MU_WIDTH;
    localparam int PW  = 2*W-1;
    localparam int MPW = MUW+W-1;
    localparam logic [2*W-1:0] CAP_P   = {{(W-1){1'b0}}, 1'b1, {W{1'b0}}};
    localparam logic [MPW:0]   CAP_M   = {{(MPW-W){1'b0}}, 1'b1, {W{1'b0}}};
    localparam logic [2*W-1:0] HALF_P  = {{(2*W-1){1'b0}}, 1'b1} << (F-1);
    localparam logic [MPW:0]   HALF_M  = {{MPW{1'b0}}, 1'b1} << (F-1);
    localparam logic [W+1:0]   SMAX_E  = ({{(W+1){1'b0}}, 1'b1} << (W-1)) - 1'b1;
    localparam logic [W+1:0]   SMIN_E  = ~SMAX_E;

    logic [6:1]            v_reg;

    logic                  kind1_reg, kind2_reg, kind3_reg, kind4_reg, kind5_reg;
    logic [MUW-1:0]        mu1_reg, mu2_reg, mu3_reg, mu4_reg;
    logic [2:0][W-1:0]     p1_reg, p2_reg;
    logic [2:0]            neg1_reg, neg2_reg;
    logic [2:0][W-1:0]     my1_reg;
    logic [2:0][W-2:0]     r1_reg;
    logic [2:0][PW-1:0]    prod2_reg;
    logic [2:0][W-1:0]     z3_reg;
    logic [W-2:0]          pn4_reg, pn5_reg;
    logic [W-1:0]          t14_reg, t24_reg, t15_reg, t25_reg;
    logic [W-1:0]          mt14_reg, mt24_reg, mt15_reg, mt25_reg;
    logic [2*W-1:0]        sq15_reg, sq25_reg;
    logic [MPW-1:0]        mp5_reg;

    logic [2:0][W-1:0]     my1_next;
    logic [2:0][W-1:0]     z3_next;
    logic [2*W-1:0]        rnd   [3];
    logic [2*W-1:0]        shq   [3];
    logic [W:0]            q     [3];
    logic [W+1:0]          ze    [3];
    logic [MPW:0]          rl;
    logic [MPW:0]          shl;
    logic [W:0]            lim_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            my1_next[i] = y_in[i][W-1] ? (~y_in[i] + 1'b1) : y_in[i];
            rnd[i] = {1'b0, prod2_reg[i]} + HALF_P;
            shq[i] = rnd[i] >> F;
            q[i]   = (shq[i] > CAP_P) ? CAP_P[W:0] : shq[i][W:0];
            ze[i]  = neg2_reg[i] ? ({{2{p2_reg[i][W-1]}}, p2_reg[i]} + {1'b0, q[i]})
                                 : ({{2{p2_reg[i][W-1]}}, p2_reg[i]} - {1'b0, q[i]});
            if ($signed(ze[i]) > $signed(SMAX_E))
            begin
                z3_next[i] = SMAX_E[W-1:0];
            end
            else if ($signed(ze[i]) < $signed(SMIN_E))
            begin
                z3_next[i] = SMIN_E[W-1:0];
            end
            else
            begin
                z3_next[i] = ze[i][W-1:0];
            end
        end
        rl       = {1'b0, mp5_reg} + HALF_M;
        shl      = rl >> F;
        lim_next = (shl > CAP_M) ? CAP_M[W:0] : shl[W:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:1], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= kind_in;
            mu1_reg   <= mu_in;
            p1_reg    <= p_in;
            r1_reg    <= r_in;
            my1_reg   <= my1_next;
            for (int i = 0; i < 3; i++)
            begin
                neg1_reg[i] <= y_in[i][W-1];
            end

            kind2_reg <= kind1_reg;
            mu2_reg   <= mu1_reg;
            p2_reg    <= p1_reg;
            neg2_reg  <= neg1_reg;
            for (int i = 0; i < 3; i++)
            begin
                prod2_reg[i] <= PW'({1'b0, r1_reg[i]} * my1_reg[i]);
            end

            kind3_reg <= kind2_reg;
            mu3_reg   <= mu2_reg;
            z3_reg    <= z3_next;

            kind4_reg <= kind3_reg;
            mu4_reg   <= mu3_reg;
            pn4_reg   <= z3_reg[0][W-1] ? '0 : z3_reg[0][W-2:0];
            t14_reg   <= z3_reg[1];
            t24_reg   <= z3_reg[2];
            mt14_reg  <= z3_reg[1][W-1] ? (~z3_reg[1] + 1'b1) : z3_reg[1];
            mt24_reg  <= z3_reg[2][W-1] ? (~z3_reg[2] + 1'b1) : z3_reg[2];

            kind5_reg <= kind4_reg;
            pn5_reg   <= pn4_reg;
            t15_reg   <= t14_reg;
            t25_reg   <= t24_reg;
            mt15_reg  <= mt14_reg;
            mt25_reg  <= mt24_reg;
            sq15_reg  <= mt14_reg * mt14_reg;
            sq25_reg  <= mt24_reg * mt24_reg;
            mp5_reg   <= MPW'(mu4_reg * pn4_reg);

            kind_out  <= kind5_reg;
            pn_out    <= pn5_reg;
            t1_out    <= t15_reg;
            t2_out    <= t25_reg;
            mt1_out   <= mt15_reg;
            mt2_out   <= mt25_reg;
            sq_out    <= sq15_reg + sq25_reg;
            lim_out   <= lim_next;
        end
    end

    assign valid_out = v_reg[6];

endmodule

// ===== sv/cicu_sqrt_step.sv =====
// ----------------------------------------------------------------------------
// Contact impulse cone update square root step
// One stage of the digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cicu_sqrt_step #(
    parameter int W  = cicu_pkg::DATA_WIDTH,
    parameter int SW = 6*cicu_pkg::DATA_WIDTH+1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  logic [2*W-1:0]  rad_in,
    input  logic [W+1:0]    rem_in,
    input  logic [W-1:0]    root_in,
    input  logic [SW-1:0]   side_in,
    output logic            valid_out,
    output logic [2*W-1:0]  rad_out,
    output logic [W+1:0]    rem_out,
    output logic [W-1:0]    root_out,
    output logic [SW-1:0]   side_out
);

    logic [W+1:0] rem_sh;
    logic [W+1:0] trial;
    logic         ge;

    always_comb
    begin
        rem_sh = {rem_in[W-1:0], rad_in[2*W-1:2*W-2]};
        trial  = {root_in, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (en)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_out  <= {rad_in[2*W-3:0], 2'b00};
            rem_out  <= ge ? (rem_sh - trial) : rem_sh;
            root_out <= {root_in[W-2:0], ge};
            side_out <= side_in;
        end
    end

endmodule

// ===== sv/cicu_div_step.sv =====
// ----------------------------------------------------------------------------
// Contact impulse cone update divider step
// One restoring division stage for both tangent lanes, one quotient bit each.
// ----------------------------------------------------------------------------
module cicu_div_step #(
    parameter int W  = cicu_pkg::DATA_WIDTH,
    parameter int SW = 3*cicu_pkg::DATA_WIDTH+1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  logic [W-1:0]        d_in,
    input  logic [1:0][W-1:0]   rem_in,
    input  logic [1:0][W-1:0]   num_in,
    input  logic [1:0][W-1:0]   q_in,
    input  logic [SW-1:0]       side_in,
    output logic                valid_out,
    output logic [W-1:0]        d_out,
    output logic [1:0][W-1:0]   rem_out,
    output logic [1:0][W-1:0]   num_out,
    output logic [1:0][W-1:0]   q_out,
    output logic [SW-1:0]       side_out
);

    logic [1:0][W:0]   r2;
    logic [1:0]        ge;
    logic [1:0][W:0]   diff;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            r2[i]   = {rem_in[i], num_in[i][W-1]};
            ge[i]   = r2[i] >= {1'b0, d_in};
            diff[i] = r2[i] - {1'b0, d_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (en)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_out    <= d_in;
            side_out <= side_in;
            for (int i = 0; i < 2; i++)
            begin
                rem_out[i] <= ge[i] ? diff[i][W-1:0] : r2[i][W-1:0];
                num_out[i] <= {num_in[i][W-2:0], 1'b0};
                q_out[i]   <= {q_in[i][W-2:0], ge[i]};
            end
        end
    end

endmodule

// ===== sv/contact_impulse_cone_update.sv =====
// ----------------------------------------------------------------------------
// Contact impulse cone update
// Projected-Jacobi impulse update of one contact onto its friction cone.
// ----------------------------------------------------------------------------
// One contact enters per cycle unless the pipeline is halted. Its path runs
// through six front stages, one square root stage per root bit, one multiply
// stage, one divider stage per quotient bit for both tangents, and the output
// register. The whole pipeline halts while a result waits at the output, so
// in_ready follows out_ready whenever out_valid is set.
module contact_impulse_cone_update #(
    parameter int DATA_WIDTH = cicu_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = cicu_pkg::FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                contact_kind,
    input  logic [cicu_pkg::MU_WIDTH-1:0]       friction_coeff,
    input  logic signed [DATA_WIDTH-1:0]        p_normal,
    input  logic signed [DATA_WIDTH-1:0]        p_tangent1,
    input  logic signed [DATA_WIDTH-1:0]        p_tangent2,
    input  logic signed [DATA_WIDTH-1:0]        y_normal,
    input  logic signed [DATA_WIDTH-1:0]        y_tangent1,
    input  logic signed [DATA_WIDTH-1:0]        y_tangent2,
    input  logic [DATA_WIDTH-2:0]               r_normal,
    input  logic [DATA_WIDTH-2:0]               r_tangent1,
    input  logic [DATA_WIDTH-2:0]               r_tangent2,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [DATA_WIDTH-2:0]               new_normal,
    output logic signed [DATA_WIDTH-1:0]        new_tangent1,
    output logic signed [DATA_WIDTH-1:0]        new_tangent2
);

    `include "assert_macros.svh"

    localparam int W     = DATA_WIDTH;
    localparam int SQ_SW = 6*W+1;
    localparam int DV_SW = 3*W+1;

    logic en;

    logic            fr_valid;
    logic            fr_kind;
    logic [W-2:0]    fr_pn;
    logic [W:0]      fr_lim;
    logic [W-1:0]    fr_t1, fr_t2, fr_mt1, fr_mt2;
    logic [2*W-1:0]  fr_sq;

    logic            sq_valid [0:W];
    logic [2*W-1:0]  sq_rad   [0:W];
    logic [W+1:0]    sq_rem   [0:W];
    logic [W-1:0]    sq_root  [0:W];
    logic [SQ_SW-1:0] sq_side [0:W];

    logic            sq_kind;
    logic [W-2:0]    sq_pn;
    logic [W:0]      sq_lim;
    logic [W-1:0]    sq_t1, sq_t2, sq_mt1, sq_mt2;

    logic                m_valid_reg;
    logic [DV_SW-1:0]    m_side_reg;
    logic [W-1:0]        m_d_reg;
    logic [1:0][2*W-1:0] m_n_reg;
    logic                byp_next;

    logic               dv_valid [0:W];
    logic [W-1:0]       dv_d     [0:W];
    logic [1:0][W-1:0]  dv_rem   [0:W];
    logic [1:0][W-1:0]  dv_num   [0:W];
    logic [1:0][W-1:0]  dv_q     [0:W];
    logic [DV_SW-1:0]   dv_side  [0:W];

    logic               dv_kind;
    logic [W-2:0]       dv_pn;
    logic               dv_byp;
    logic [1:0][W-1:0]  dv_t;
    logic [1:0][W-1:0]  lane_mag;
    logic [1:0][W-1:0]  lane_next;

    logic               out_valid_reg;
    logic [W-2:0]       new_normal_reg;
    logic [W-1:0]       new_t1_reg, new_t2_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    cicu_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid && in_ready),
        .kind_in   (contact_kind),
        .mu_in     (friction_coeff),
        .p_in      ({p_tangent2, p_tangent1, p_normal}),
        .y_in      ({y_tangent2, y_tangent1, y_normal}),
        .r_in      ({r_tangent2, r_tangent1, r_normal}),
        .valid_out (fr_valid),
        .kind_out  (fr_kind),
        .pn_out    (fr_pn),
        .lim_out   (fr_lim),
        .t1_out    (fr_t1),
        .t2_out    (fr_t2),
        .mt1_out   (fr_mt1),
        .mt2_out   (fr_mt2),
        .sq_out    (fr_sq)
    );

    assign sq_valid[0] = fr_valid;
    assign sq_rad[0]   = fr_sq;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {fr_kind, fr_pn, fr_lim, fr_t1, fr_t2, fr_mt1, fr_mt2};

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        cicu_sqrt_step #(
            .W  (W),
            .SW (SQ_SW)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_valid[k]),
            .rad_in    (sq_rad[k]),
            .rem_in    (sq_rem[k]),
            .root_in   (sq_root[k]),
            .side_in   (sq_side[k]),
            .valid_out (sq_valid[k+1]),
            .rad_out   (sq_rad[k+1]),
            .rem_out   (sq_rem[k+1]),
            .root_out  (sq_root[k+1]),
            .side_out  (sq_side[k+1])
        );
    end

    assign sq_mt2  = sq_side[W][W-1:0];
    assign sq_mt1  = sq_side[W][2*W-1:W];
    assign sq_t2   = sq_side[W][3*W-1:2*W];
    assign sq_t1   = sq_side[W][4*W-1:3*W];
    assign sq_lim  = sq_side[W][5*W:4*W];
    assign sq_pn   = sq_side[W][6*W-1:5*W+1];
    assign sq_kind = sq_side[W][6*W];

    assign byp_next = (sq_root[W] == '0) || (sq_lim >= {1'b0, sq_root[W]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= sq_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_side_reg <= {sq_kind, sq_pn, byp_next, sq_t1, sq_t2};
            m_d_reg    <= sq_root[W];
            m_n_reg[0] <= sq_mt1 * sq_lim[W-1:0];
            m_n_reg[1] <= sq_mt2 * sq_lim[W-1:0];
        end
    end

    assign dv_valid[0]  = m_valid_reg;
    assign dv_d[0]      = m_d_reg;
    assign dv_side[0]   = m_side_reg;
    assign dv_rem[0][0] = m_n_reg[0][2*W-1:W];
    assign dv_rem[0][1] = m_n_reg[1][2*W-1:W];
    assign dv_num[0][0] = m_n_reg[0][W-1:0];
    assign dv_num[0][1] = m_n_reg[1][W-1:0];
    assign dv_q[0]      = '0;

    for (genvar k = 0; k < W; k++)
    begin : g_div
        cicu_div_step #(
            .W  (W),
            .SW (DV_SW)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_valid[k]),
            .d_in      (dv_d[k]),
            .rem_in    (dv_rem[k]),
            .num_in    (dv_num[k]),
            .q_in      (dv_q[k]),
            .side_in   (dv_side[k]),
            .valid_out (dv_valid[k+1]),
            .d_out     (dv_d[k+1]),
            .rem_out   (dv_rem[k+1]),
            .num_out   (dv_num[k+1]),
            .q_out     (dv_q[k+1]),
            .side_out  (dv_side[k+1])
        );
    end

    assign dv_t[1]  = dv_side[W][W-1:0];
    assign dv_t[0]  = dv_side[W][2*W-1:W];
    assign dv_byp   = dv_side[W][2*W];
    assign dv_pn    = dv_side[W][3*W-1:2*W+1];
    assign dv_kind  = dv_side[W][3*W];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            lane_mag[i] = dv_q[W][i]
                        + W'({dv_rem[W][i], 1'b0} >= {1'b0, dv_d[W]});
            if (!dv_kind)
            begin
                lane_next[i] = '0;
            end
            else if (dv_byp)
            begin
                lane_next[i] = dv_t[i];
            end
            else if (dv_t[i][W-1])
            begin
                lane_next[i] = ~lane_mag[i] + 1'b1;
            end
            else
            begin
                lane_next[i] = lane_mag[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_normal_reg <= dv_pn;
            new_t1_reg     <= lane_next[0];
            new_t2_reg     <= lane_next[1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_normal   = new_normal_reg;
    assign new_tangent1 = new_t1_reg;
    assign new_tangent2 = new_t2_reg;

    `ASSERT_IMPLIES(a_sqrt_rem, sq_valid[W], sq_rem[W] <= {1'b0, sq_root[W], 1'b0})
    `ASSERT_IMPLIES(a_div_rem, dv_valid[W] && dv_kind && !dv_byp, dv_rem[W][0] < dv_d[W])
    `ASSERT_NEXT(a_stall_hold, !en && m_valid_reg, m_valid_reg && $stable(m_d_reg))

endmodule

// ===== test/contact_impulse_cone_update_test.sv =====
// ----------------------------------------------------------------------------
// Contact impulse cone update testbench
// Sends a table of edge-case contacts, then random ones, through the cone
// update pipeline with random idling on both handshakes. Each result is
// checked against its table row's values or a local fixed-point cone model.
// ----------------------------------------------------------------------------
module contact_impulse_cone_update_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = cicu_pkg::DATA_WIDTH;
    localparam int FB = cicu_pkg::FRAC_BITS;
    localparam int MW = cicu_pkg::MU_WIDTH;
    localparam int RANDOM_COUNT = 400;
    localparam int DIRECTED_COUNT = 12;
    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483648;
    localparam logic [63:0] CAP = 64'd1 << DW;

    typedef struct {
        bit                   check;
        logic                 kind;
        logic [MW-1:0]        mu;
        logic [DW-1:0]        pn, pt1, pt2, yn, yt1, yt2;
        logic [DW-2:0]        rn, rt1, rt2;
        logic [DW-2:0]        en;
        logic [DW-1:0]        e1, e2;
    } contact_t;

    typedef struct {
        logic [DW-2:0] normal;
        logic [DW-1:0] tangent1, tangent2;
    } impulse_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 contact_kind;
    logic [MW-1:0]        friction_coeff;
    logic signed [DW-1:0] p_normal, p_tangent1, p_tangent2;
    logic signed [DW-1:0] y_normal, y_tangent1, y_tangent2;
    logic [DW-2:0]        r_normal, r_tangent1, r_tangent2;
    logic                 out_valid;
    logic                 out_ready;
    logic [DW-2:0]        new_normal;
    logic signed [DW-1:0] new_tangent1, new_tangent2;

    impulse_t pending_impulses[$];
    int       error_count = 0;
    int       sent_count = 0;
    int       result_count = 0;
    int       scaled_count = 0;
    bit       quiet_phase = 0;
    bit       long_hold_done = 0;
    contact_t directed[DIRECTED_COUNT];

    contact_impulse_cone_update DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .contact_kind(contact_kind), .friction_coeff(friction_coeff),
        .p_normal(p_normal), .p_tangent1(p_tangent1), .p_tangent2(p_tangent2),
        .y_normal(y_normal), .y_tangent1(y_tangent1), .y_tangent2(y_tangent2),
        .r_normal(r_normal), .r_tangent1(r_tangent1), .r_tangent2(r_tangent2),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_normal(new_normal), .new_tangent1(new_tangent1),
        .new_tangent2(new_tangent2)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("contact_impulse_cone_update_test: done, errors");
        $finish;
    end

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] round_cap(logic [127:0] prod);
        logic [127:0] q;
        q = (prod + (128'd1 << (FB - 1))) >> FB;
        return q > {64'd0, CAP} ? CAP : q[63:0];
    endfunction

    function automatic longint row_impulse(longint p, longint y, logic [DW-2:0] r);
        longint q;
        longint z;
        q = longint'(round_cap({97'd0, r} * {64'd0, magnitude(y)}));
        z = y < 0 ? p + q : p - q;
        if (z > SAT_MAX) z = SAT_MAX;
        if (z < SAT_MIN) z = SAT_MIN;
        return z;
    endfunction

    function automatic longint scale_tangent(longint t, logic [63:0] lim, logic [63:0] tn);
        logic [127:0] n;
        logic [127:0] q;
        logic [127:0] rem;
        n = {64'd0, magnitude(t)} * {64'd0, lim};
        q = n / tn;
        rem = n % tn;
        if (rem >= tn - rem) q = q + 1;
        return t < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic impulse_t cone_projection(contact_t c);
        impulse_t res;
        longint zn, t1, t2, n1, n2;
        logic [127:0] sum;
        logic [63:0] tn, cand, lim;
        zn = row_impulse(longint'($signed(c.pn)), longint'($signed(c.yn)), c.rn);
        if (zn < 0) zn = 0;
        n1 = 0;
        n2 = 0;
        if (c.kind)
        begin
            t1 = row_impulse(longint'($signed(c.pt1)), longint'($signed(c.yt1)), c.rt1);
            t2 = row_impulse(longint'($signed(c.pt2)), longint'($signed(c.yt2)), c.rt2);
            sum = {64'd0, magnitude(t1)} * {64'd0, magnitude(t1)}
                + {64'd0, magnitude(t2)} * {64'd0, magnitude(t2)};
            tn = 0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = tn | (64'd1 << b);
                if ({64'd0, cand} * {64'd0, cand} <= sum) tn = cand;
            end
            lim = round_cap({108'd0, c.mu} * {64'd0, 64'(zn)});
            if (tn == 0 || lim >= tn)
            begin
                n1 = t1;
                n2 = t2;
            end
            else
            begin
                n1 = scale_tangent(t1, lim, tn);
                n2 = scale_tangent(t2, lim, tn);
            end
        end
        res.normal = zn[DW-2:0];
        res.tangent1 = n1[DW-1:0];
        res.tangent2 = n2[DW-1:0];
        return res;
    endfunction

    function automatic logic [DW-1:0] random_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return DW'($signed(20'($urandom)));
            2: return DW'($signed(24'($urandom)));
            default: return {{(DW - 16){1'b0}}, 16'($urandom)} << $urandom_range(0, 8);
        endcase
    endfunction

    function automatic contact_t random_contact();
        contact_t c;
        c.check = 0;
        c.kind = ($urandom_range(0, 3) != 0);
        c.mu = ($urandom_range(0, 1) == 1) ? MW'($urandom) : MW'($urandom_range(0, 65536));
        c.pn = random_word();
        c.pt1 = random_word();
        c.pt2 = random_word();
        c.yn = random_word();
        c.yt1 = random_word();
        c.yt2 = random_word();
        c.rn = ($urandom_range(0, 2) == 0) ? (DW - 1)'($urandom) : (DW - 1)'($urandom_range(0, 131072));
        c.rt1 = ($urandom_range(0, 2) == 0) ? (DW - 1)'($urandom) : (DW - 1)'($urandom_range(0, 131072));
        c.rt2 = ($urandom_range(0, 2) == 0) ? (DW - 1)'($urandom) : (DW - 1)'($urandom_range(0, 131072));
        return c;
    endfunction

    task automatic send_contact(contact_t c);
        impulse_t e;
        if (!quiet_phase && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1;
        contact_kind <= c.kind;
        friction_coeff <= c.mu;
        p_normal <= c.pn;
        p_tangent1 <= c.pt1;
        p_tangent2 <= c.pt2;
        y_normal <= c.yn;
        y_tangent1 <= c.yt1;
        y_tangent2 <= c.yt2;
        r_normal <= c.rn;
        r_tangent1 <= c.rt1;
        r_tangent2 <= c.rt2;
        do @(posedge clk); while (!in_ready);
        e = cone_projection(c);
        if (c.check)
        begin
            if (e.normal != c.en || e.tangent1 != c.e1 || e.tangent2 != c.e2)
                $display("%t table row disagrees with model: %h %h %h", $realtime,
                         c.en, c.e1, c.e2);
            e.normal = c.en;
            e.tangent1 = c.e1;
            e.tangent2 = c.e2;
        end
        if (c.kind && (e.tangent1 != c.pt1 || e.tangent2 != c.pt2)) scaled_count++;
        pending_impulses = {pending_impulses, e};
        sent_count++;
    endtask

    task automatic check_field(string name, logic [DW-1:0] exp, logic [DW-1:0] act);
        if (exp !== act)
        begin
            $display("%t %s mismatch: expected %h actual %h", $realtime, name, exp, act);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        impulse_t e;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (pending_impulses.size() == 0)
            begin
                $display("%t unexpected result: expected none actual %h %h %h", $realtime,
                         new_normal, new_tangent1, new_tangent2);
                error_count++;
            end
            else
            begin
                e = pending_impulses.pop_front();
                check_field("new_normal", {1'b0, e.normal}, {1'b0, new_normal});
                check_field("new_tangent1", e.tangent1, new_tangent1);
                check_field("new_tangent2", e.tangent2, new_tangent2);
            end
        end
    end

    initial
    begin
        out_ready <= 0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else if (!long_hold_done && sent_count >= 120)
            begin
                long_hold_done = 1;
                out_ready <= 0;
                repeat (300) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
        end
    end

    initial
    begin
        int wait_cycles;
        directed[0]  = '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        directed[1]  = '{1, 0, 20'hFFFFF, 32'h7FFFFFFF, 32'h12345, 32'h6789, 0, 0, 0,
                         0, 0, 0, 31'h7FFFFFFF, 0, 0};
        directed[2]  = '{1, 1, 20'hFFFFF, 32'hFFFFFFFB, 100, 200, 0, 0, 0,
                         0, 0, 0, 0, 0, 0};
        directed[3]  = '{1, 0, 0, 32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0,
                         31'h7FFFFFFF, 0, 0, 31'h7FFFFFFF, 0, 0};
        directed[4]  = '{1, 1, 20'hFFFFF, 32'h7FFFFFFF, 32'h80000000, 0, 0,
                         32'h7FFFFFFF, 0, 0, 31'h7FFFFFFF, 0, 31'h7FFFFFFF,
                         32'h80000000, 0};
        directed[5]  = '{1, 0, 0, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0,
                         0, 0, 0, 0, 0, 0};
        directed[6]  = '{0, 1, 20'h08000, 32'h10000, 32'h30000, 32'h40000, 0, 0, 0,
                         0, 0, 0, 0, 0, 0};
        directed[7]  = '{0, 1, 20'h10000, 32'h20000, 32'hFFFD0000, 32'h40000,
                         32'h8000, 32'hFFFF0000, 32'h18000, 31'h10000, 31'h8000,
                         31'h20000, 0, 0, 0};
        directed[8]  = '{0, 1, 20'h00001, 32'h00001, 32'h7FFFFFFF, 32'h80000000,
                         32'h1, 32'h1, 32'h1, 31'h8000, 31'h8000, 31'h8000, 0, 0, 0};
        directed[9]  = '{0, 1, 20'hFFFFF, 32'hFFFF8000, 32'h1000, 32'hFFFFF000,
                         32'hFFFFFFFF, 32'h2, 32'h3, 31'h7FFFFFFF, 31'h1, 31'h7FFFFFFF,
                         0, 0, 0};
        directed[10] = '{0, 0, 20'h55555, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                         32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 31'h55555555,
                         31'h2AAAAAAA, 31'h55555555, 0, 0, 0};
        directed[11] = '{0, 1, 20'hAAAAA, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                         32'h55555555, 32'hAAAAAAAA, 32'h55555555, 31'h2AAAAAAA,
                         31'h55555555, 31'h2AAAAAAA, 0, 0, 0};

        rst_n = 0;
        in_valid <= 0;
        contact_kind <= 0;
        friction_coeff <= 0;
        p_normal <= 0;
        p_tangent1 <= 0;
        p_tangent2 <= 0;
        y_normal <= 0;
        y_tangent1 <= 0;
        y_tangent2 <= 0;
        r_normal <= 0;
        r_tangent1 <= 0;
        r_tangent2 <= 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++) send_contact(directed[i]);
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i >= RANDOM_COUNT - 60) quiet_phase = 1;
            send_contact(random_contact());
        end
        in_valid <= 0;

        wait_cycles = 0;
        while (pending_impulses.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (2 * DW + 16) @(posedge clk);
        if (pending_impulses.size() != 0)
        begin
            $display("%t results missing: expected %0d more actual 0", $realtime,
                     pending_impulses.size());
            error_count++;
        end

        $display("Sent %0d contacts (%0d table rows), checked %0d results.",
                 sent_count, DIRECTED_COUNT, result_count);
        $display("Full contacts whose tangent impulses changed: %0d.", scaled_count);
        if (error_count == 0)
            $display("contact_impulse_cone_update_test: done, clean");
        else
            $display("contact_impulse_cone_update_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cicu_pkg.sv
sv/cicu_front.sv
sv/cicu_sqrt_step.sv
sv/cicu_div_step.sv
sv/contact_impulse_cone_update.sv
test/contact_impulse_cone_update_test.sv
